/* hw/rtl/tpcp_pkg.sv */
// tpcp_pkg: shared types and constants for the time/period command parser
// no dependencies; used by the top, front, queue and back modules
`default_nettype none

package tpcp_pkg;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_FORMAT  = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	// command kind codes
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_TIME   = 2'd1;
	localparam logic [1:0] KIND_PERIOD = 2'd2;

	localparam int PREFIX_LEN = 8;
	localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{
		8'h53, 8'h45, 8'h54, 8'h5F, 8'h54, 8'h49, 8'h4D, 8'h45
	};

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_EQUAL = 8'h3D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// classified character as it travels from front to back
	typedef struct packed {
		logic                  eol;
		logic                  is_digit;
		logic [3:0]            digit;
		logic                  is_colon;
		logic                  is_eq;
		logic                  is_space;
		logic [PREFIX_LEN-1:0] pmatch;
	} item_t;

endpackage

`default_nettype wire

/* hw/rtl/time_period_command_parser_unit.sv */
// time_period_command_parser_unit: top level of the command line parser
// depends on tpcp_pkg, tpcp_front, tpcp_queue, tpcp_back
//
// channel  dir  payload
// s_*      in   tdata[7:0] char_code, tlast end_of_line
// m_*      out  tdata status, cmd_kind, hours, minutes, seconds, period
//
// one character per cycle unless an end marker waits for the result slot; an item
// passes classifier, a two-entry queue and the parser register; the result valid
// flag is set when the parser takes the end marker from the queue
// reset clears the queue, the parser state and the result valid flag
// the parser stalls only on an end marker while a result is still waiting
// characters keep flowing into the queue until it is full
`default_nettype none

module time_period_command_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // [1:0] status, [3:2] cmd_kind, [8:4] hours,
	                                    // [14:9] minutes, [20:15] seconds, [26:21] period
);

	tpcp_pkg::item_t front_item;
	tpcp_pkg::item_t q_head;
	logic            q_full;
	logic            q_push;
	logic            q_valid;
	logic            q_pop;

	logic [1:0] status;
	logic [1:0] cmd_kind;
	logic [4:0] hours;
	logic [5:0] minutes;
	logic [5:0] seconds;
	logic [5:0] period;

	tpcp_front u_front (
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.char_code   (s_tdata),
		.end_of_line (s_tlast),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (front_item)
	);

	tpcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	tpcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd_kind  (cmd_kind),
		.hours     (hours),
		.minutes   (minutes),
		.seconds   (seconds),
		.period    (period)
	);

	assign m_tdata = {5'd0, period, seconds, minutes, hours, cmd_kind, status};

endmodule

`default_nettype wire

/* hw/rtl/tpcp_front.sv */
// tpcp_front: accepts characters and classifies them for the parser
// depends on tpcp_pkg
`default_nettype none

module tpcp_front (
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    char_code,
	input  wire logic          end_of_line,
	input  wire logic          q_full,
	output logic               q_push,
	output tpcp_pkg::item_t    q_item
);

	always_comb begin
		q_item          = '0;
		q_item.eol      = end_of_line;
		q_item.is_digit = (char_code >= tpcp_pkg::CHAR_ZERO) &&
			(char_code <= tpcp_pkg::CHAR_NINE);
		q_item.digit    = char_code[3:0];
		q_item.is_colon = (char_code == tpcp_pkg::CHAR_COLON);
		q_item.is_eq    = (char_code == tpcp_pkg::CHAR_EQUAL);
		q_item.is_space = (char_code == tpcp_pkg::CHAR_SPACE);
		// one compare per prefix position, back picks the one it needs
		for (int i = 0; i < tpcp_pkg::PREFIX_LEN; i++) begin
			q_item.pmatch[i] = (char_code == tpcp_pkg::PREFIX_TEXT[i]);
		end
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

/* hw/rtl/tpcp_queue.sv */
// tpcp_queue: two-entry queue of classified items between front and back
// depends on tpcp_pkg
`default_nettype none

module tpcp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire tpcp_pkg::item_t push_item,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output tpcp_pkg::item_t      head
);

	tpcp_pkg::item_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/tpcp_back.sv */
// tpcp_back: parser state machine and result register
// depends on tpcp_pkg
`default_nettype none

module tpcp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire tpcp_pkg::item_t q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [1:0]           status,
	output logic [1:0]           cmd_kind,
	output logic [4:0]           hours,
	output logic [5:0]           minutes,
	output logic [5:0]           seconds,
	output logic [5:0]           period
);

	localparam logic [2:0] PH_SKIP     = 3'd0;
	localparam logic [2:0] PH_PREFIX   = 3'd1;
	localparam logic [2:0] PH_TIME     = 3'd2;
	localparam logic [2:0] PH_PERIOD   = 3'd3;
	localparam logic [2:0] PH_UNKNOWN  = 3'd4;
	localparam logic [2:0] PH_T_FMT    = 3'd5;
	localparam logic [2:0] PH_TIME_FMT = 3'd6;

	localparam logic [6:0] ACC_MAX = 7'd127;

	logic [2:0] phase_q;
	logic [3:0] match_pos_q;
	logic [3:0] value_pos_q;
	logic [6:0] hour_acc_q;
	logic [6:0] minute_acc_q;
	logic [6:0] second_acc_q;
	logic [6:0] period_acc_q;
	logic       format_bad_q;

	logic [2:0]  phase_d;
	logic [3:0]  match_pos_d;
	logic [3:0]  value_pos_d;
	logic [6:0]  hour_acc_d;
	logic [6:0]  minute_acc_d;
	logic [6:0]  second_acc_d;
	logic [6:0]  period_acc_d;
	logic        format_bad_d;

	logic [1:0]  res_status;
	logic [1:0]  res_kind;
	logic [4:0]  res_hours;
	logic [5:0]  res_minutes;
	logic [5:0]  res_seconds;
	logic [5:0]  res_period;

	logic        prefix_hit;
	logic [10:0] period_next;

	// an end marker needs the result slot, plain characters never wait
	assign q_pop = q_valid && (!q_head.eol || !out_valid || out_ready);

	assign prefix_hit = !match_pos_q[3] && q_head.pmatch[match_pos_q[2:0]];
	assign period_next = {1'b0, period_acc_q, 3'b000} + {3'b000, period_acc_q, 1'b0} +
		{7'd0, q_head.digit};

	always_comb begin
		phase_d      = phase_q;
		match_pos_d  = match_pos_q;
		value_pos_d  = value_pos_q;
		hour_acc_d   = hour_acc_q;
		minute_acc_d = minute_acc_q;
		second_acc_d = second_acc_q;
		period_acc_d = period_acc_q;
		format_bad_d = format_bad_q;

		res_status  = tpcp_pkg::ST_UNKNOWN;
		res_kind    = tpcp_pkg::KIND_NONE;
		res_hours   = '0;
		res_minutes = '0;
		res_seconds = '0;
		res_period  = '0;

		if (!q_head.eol) begin
			case (phase_q)
				PH_SKIP, PH_PREFIX: begin
					if (phase_q == PH_PREFIX || !q_head.is_space) begin
						if (prefix_hit) begin
							match_pos_d = match_pos_q + 4'd1;
							phase_d     = PH_PREFIX;
						end else if (match_pos_q == 4'd5 && q_head.is_eq) begin
							phase_d = PH_PERIOD;
						end else if (match_pos_q == 4'd8 && q_head.is_eq) begin
							phase_d = PH_TIME;
						end else if (match_pos_q < 4'd5) begin
							phase_d = PH_UNKNOWN;
						end else if (match_pos_q < 4'd8) begin
							phase_d = PH_T_FMT;
						end else begin
							phase_d = PH_TIME_FMT;
						end
					end
				end
				PH_TIME: begin
					if (value_pos_q >= 4'd8) begin
						value_pos_d = 4'd9;
					end else begin
						value_pos_d = value_pos_q + 4'd1;
						if (value_pos_q == 4'd2 || value_pos_q == 4'd5) begin
							if (!q_head.is_colon) begin
								format_bad_d = 1'b1;
							end
						end else if (!q_head.is_digit) begin
							format_bad_d = 1'b1;
						end else if (value_pos_q < 4'd2) begin
							hour_acc_d = 7'({hour_acc_q, 3'b000} +
								{2'b00, hour_acc_q, 1'b0} + {6'd0, q_head.digit});
						end else if (value_pos_q < 4'd5) begin
							minute_acc_d = 7'({minute_acc_q, 3'b000} +
								{2'b00, minute_acc_q, 1'b0} + {6'd0, q_head.digit});
						end else begin
							second_acc_d = 7'({second_acc_q, 3'b000} +
								{2'b00, second_acc_q, 1'b0} + {6'd0, q_head.digit});
						end
					end
				end
				PH_PERIOD: begin
					value_pos_d = 4'd1;
					if (!q_head.is_digit) begin
						format_bad_d = 1'b1;
					end else if (period_next > {4'd0, ACC_MAX}) begin
						period_acc_d = ACC_MAX;
					end else begin
						period_acc_d = period_next[6:0];
					end
				end
				default: begin
				end
			endcase
		end else begin
			case (phase_q)
				PH_PREFIX: begin
					if (match_pos_q >= 4'd8) begin
						res_status = tpcp_pkg::ST_FORMAT;
						res_kind   = tpcp_pkg::KIND_TIME;
					end else if (match_pos_q >= 4'd5) begin
						res_status = tpcp_pkg::ST_FORMAT;
						res_kind   = tpcp_pkg::KIND_PERIOD;
					end
				end
				PH_T_FMT: begin
					res_status = tpcp_pkg::ST_FORMAT;
					res_kind   = tpcp_pkg::KIND_PERIOD;
				end
				PH_TIME_FMT: begin
					res_status = tpcp_pkg::ST_FORMAT;
					res_kind   = tpcp_pkg::KIND_TIME;
				end
				PH_TIME: begin
					res_kind = tpcp_pkg::KIND_TIME;
					if (format_bad_q || value_pos_q != 4'd8) begin
						res_status = tpcp_pkg::ST_FORMAT;
					end else if (hour_acc_q > 7'd23 || minute_acc_q > 7'd59 ||
						second_acc_q > 7'd59) begin
						res_status = tpcp_pkg::ST_RANGE;
					end else begin
						res_status  = tpcp_pkg::ST_OK;
						res_hours   = hour_acc_q[4:0];
						res_minutes = minute_acc_q[5:0];
						res_seconds = second_acc_q[5:0];
					end
				end
				PH_PERIOD: begin
					res_kind = tpcp_pkg::KIND_PERIOD;
					if (format_bad_q || value_pos_q == 4'd0) begin
						res_status = tpcp_pkg::ST_FORMAT;
					end else if (period_acc_q < 7'd2 || period_acc_q > 7'd60) begin
						res_status = tpcp_pkg::ST_RANGE;
					end else begin
						res_status = tpcp_pkg::ST_OK;
						res_period = period_acc_q[5:0];
					end
				end
				default: begin
				end
			endcase
			// back to the start state after every line
			phase_d      = PH_SKIP;
			match_pos_d  = '0;
			value_pos_d  = '0;
			hour_acc_d   = '0;
			minute_acc_d = '0;
			second_acc_d = '0;
			period_acc_d = '0;
			format_bad_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SKIP;
			match_pos_q  <= '0;
			value_pos_q  <= '0;
			hour_acc_q   <= '0;
			minute_acc_q <= '0;
			second_acc_q <= '0;
			period_acc_q <= '0;
			format_bad_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q      <= phase_d;
				match_pos_q  <= match_pos_d;
				value_pos_q  <= value_pos_d;
				hour_acc_q   <= hour_acc_d;
				minute_acc_q <= minute_acc_d;
				second_acc_q <= second_acc_d;
				period_acc_q <= period_acc_d;
				format_bad_q <= format_bad_d;
			end
			if (q_pop && q_head.eol) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.eol) begin
			status   <= res_status;
			cmd_kind <= res_kind;
			hours    <= res_hours;
			minutes  <= res_minutes;
			seconds  <= res_seconds;
			period   <= res_period;
		end
	end

endmodule

`default_nettype wire
